### rtl/pgc_pkg.sv
// shared types, constants and helpers of the parity grid corrector
`timescale 1ns / 1ps
package pgc_pkg;

  localparam int GRID_SIDE = 7;
  localparam int DATA_SIDE = 6;
  localparam int GRID_W    = GRID_SIDE * GRID_SIDE;
  localparam int DATA_W    = DATA_SIDE * DATA_SIDE;

  typedef logic [GRID_W-1:0]    grid_t;
  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [DATA_SIDE-1:0] line_t;

  typedef enum logic [1:0] {
    ST_CLEAN         = 2'd0,
    ST_CORRECTED     = 2'd1,
    ST_UNCORRECTABLE = 2'd2
  } status_t;

  // data bits (r,c) for r,c in 0..5, packed at r*6+c
  function automatic data_t pgc_data_of(grid_t g);
    data_t d;
    for (int r = 0; r < DATA_SIDE; r++) begin
      for (int c = 0; c < DATA_SIDE; c++) begin
        d[r*DATA_SIDE+c] = g[r*GRID_SIDE+c];
      end
    end
    return d;
  endfunction

endpackage

### rtl/pgc_if.sv
// valid/ready channel interfaces for grid items and result items
`timescale 1ns / 1ps
interface pgc_in_if import pgc_pkg::*; ();
  logic  valid;
  logic  ready;
  grid_t received_grid;

  modport source (output valid, output received_grid, input ready);
  modport sink   (input valid, input received_grid, output ready);
endinterface

interface pgc_out_if import pgc_pkg::*; ();
  logic        valid;
  logic        ready;
  grid_t       corrected_grid;
  data_t       data_bits;
  logic [1:0]  status;

  modport source (output valid, output corrected_grid, output data_bits, output status,
                  input ready);
  modport sink   (input valid, input corrected_grid, input data_bits, input status,
                  output ready);
endinterface

### rtl/parity_grid_corrector.sv
// top level: single-error correction of a 7x7 two-dimensional parity grid
//
//  channel  | direction | payload                                  | handshake
//  ---------+-----------+------------------------------------------+-------------
//  in_ch    | in        | received_grid[48:0]                      | valid/ready
//  out_ch   | out       | corrected_grid[48:0], data_bits[35:0],   | valid/ready
//           |           | status[1:0]                              |
//
// one item per cycle sustained while out_ch is ready; an item is taken into the input
// register, then passes the correction logic into the result register
// two register stages; the xor trees and mask are combinational between them
// reset is synchronous on rst_n low and empties both stages
// a stalled result holds in the result register while the input stage may still
// fill, so a new item is taken even when a result waits; ready chains back
// through both stages
`timescale 1ns / 1ps
module parity_grid_corrector import pgc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  pgc_in_if.sink          in_ch,
  pgc_out_if.source       out_ch
);

  // input stage
  logic    s1_valid_r, s1_valid_nxt;
  grid_t   s1_grid_r;

  // result stage
  logic    out_valid_r, out_valid_nxt;
  grid_t   out_grid_r;
  data_t   out_data_r;
  status_t out_status_r;

  logic    out_free;
  logic    s1_free;
  logic    s1_move;

  // correction logic
  line_t   col_err;
  line_t   row_err;
  logic    col_multi;
  logic    row_multi;
  logic    uncorr;
  grid_t   fix_mask;
  grid_t   fixed_grid;
  logic    corner_bad;
  grid_t   grid_nxt;
  status_t status_nxt;

  // parity residue of the held result, for checking only
  logic [GRID_SIDE+DATA_SIDE-1:0] out_residue;

  // handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_free     = !s1_valid_r || out_free;
  assign s1_move     = s1_valid_r && out_free;
  assign in_ch.ready = s1_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_free) begin
      s1_valid_nxt = in_ch.valid;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && s1_free) begin
      s1_grid_r <= in_ch.received_grid;
    end
    if (s1_move) begin
      out_grid_r   <= grid_nxt;
      out_data_r   <= pgc_data_of(grid_nxt);
      out_status_r <= status_nxt;
    end
  end

  // syndromes: each column and each row xored with its parity bit
  always_comb begin
    col_err = '0;
    row_err = '0;
    for (int c = 0; c < DATA_SIDE; c++) begin
      for (int r = 0; r < GRID_SIDE; r++) begin
        col_err[c] = col_err[c] ^ s1_grid_r[r*GRID_SIDE+c];
      end
    end
    for (int r = 0; r < DATA_SIDE; r++) begin
      for (int c = 0; c < GRID_SIDE; c++) begin
        row_err[r] = row_err[r] ^ s1_grid_r[r*GRID_SIDE+c];
      end
    end
  end

  // more than one set bit: clearing the lowest one leaves something
  assign col_multi = |(col_err & (col_err - line_t'(1)));
  assign row_multi = |(row_err & (row_err - line_t'(1)));
  assign uncorr    = col_multi || row_multi;

  // flip mask: data bit where row and column meet, else the lone parity bit
  always_comb begin
    fix_mask = '0;
    if (!uncorr) begin
      for (int r = 0; r < DATA_SIDE; r++) begin
        for (int c = 0; c < DATA_SIDE; c++) begin
          fix_mask[r*GRID_SIDE+c] = row_err[r] && col_err[c];
        end
        fix_mask[r*GRID_SIDE+DATA_SIDE] = row_err[r] && !(|col_err);
      end
      for (int c = 0; c < DATA_SIDE; c++) begin
        fix_mask[DATA_SIDE*GRID_SIDE+c] = col_err[c] && !(|row_err);
      end
    end
  end

  assign fixed_grid = s1_grid_r ^ fix_mask;

  // corner against even parity of the corrected bottom row
  always_comb begin
    corner_bad = 1'b0;
    for (int c = 0; c < GRID_SIDE; c++) begin
      corner_bad = corner_bad ^ fixed_grid[DATA_SIDE*GRID_SIDE+c];
    end
  end

  always_comb begin
    grid_nxt   = s1_grid_r;
    status_nxt = ST_CLEAN;
    if (uncorr) begin
      status_nxt = ST_UNCORRECTABLE;
    end else begin
      grid_nxt = fixed_grid;
      grid_nxt[GRID_W-1] = fixed_grid[GRID_W-1] ^ corner_bad;
      if ((|col_err) || (|row_err) || corner_bad) begin
        status_nxt = ST_CORRECTED;
      end
    end
  end

  // result channel
  assign out_ch.valid          = out_valid_r;
  assign out_ch.corrected_grid = out_grid_r;
  assign out_ch.data_bits      = out_data_r;
  assign out_ch.status         = out_status_r;

  // every row and the data columns of a held result
  always_comb begin
    out_residue = '0;
    for (int r = 0; r < GRID_SIDE; r++) begin
      for (int c = 0; c < GRID_SIDE; c++) begin
        out_residue[r] = out_residue[r] ^ out_grid_r[r*GRID_SIDE+c];
      end
    end
    for (int c = 0; c < DATA_SIDE; c++) begin
      for (int r = 0; r < GRID_SIDE; r++) begin
        out_residue[GRID_SIDE+c] = out_residue[GRID_SIDE+c] ^ out_grid_r[r*GRID_SIDE+c];
      end
    end
  end

  // a corrected or clean result has even parity in every row and data column
  a_result_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_UNCORRECTABLE) |-> out_residue == '0)
    else $error("corrected grid still has a parity mismatch");

  // unless something was corrected the grid passes unchanged
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && (status_nxt != ST_CORRECTED) |=> out_grid_r == $past(s1_grid_r))
    else $error("grid altered without a correction");

  // data bits always follow the result grid
  a_data_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r == pgc_data_of(out_grid_r))
    else $error("data bits differ from corrected grid");

  // an item in the input stage moves on when the result stage is free
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("item lost between stages");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

endmodule
